// ===== rtl/pvsa_pkg.sv =====
`default_nettype none
package pvsa_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [1:0] CMD_PLAY   = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_STOP   = 2'd3;

    localparam logic [2:0] ACT_GRANTED   = 3'd0;
    localparam logic [2:0] ACT_PREEMPT   = 3'd1;
    localparam logic [2:0] ACT_REJECTED  = 3'd2;
    localparam logic [2:0] ACT_REMOVED   = 3'd3;
    localparam logic [2:0] ACT_NOT_FOUND = 3'd4;
    localparam logic [2:0] ACT_AGE       = 3'd5;
    localparam logic [2:0] ACT_STOP      = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] voice_handle;
        logic [15:0] sound_id;
        logic [7:0]  voice_priority;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] sound;
        logic [31:0] owner;
        logic [31:0] start;
    } entry_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot_index;
        logic [31:0] victim_handle;
        logic [15:0] victim_sound_id;
        logic [31:0] age_ms;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/pvsa_mem.sv =====
`default_nettype none
module pvsa_mem
    import pvsa_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int IDX_W = $clog2(SLOTS)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t slot_mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    // hold read data while the scan stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/pvsa_ctrl.sv =====
`default_nettype none
module pvsa_ctrl
    import pvsa_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int IDX_W = $clog2(SLOTS)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire req_t             in_req,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output entry_t                wr_data,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  wire entry_t           rd_data,
    output logic                  emit_valid,
    input  wire logic             emit_ready,
    output result_t               emit_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    req_t             req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [7:0]       best_prio_reg, best_prio_next;
    logic [31:0]      best_age_reg, best_age_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]      best_owner_reg, best_owner_next;
    logic [15:0]      best_sound_reg, best_sound_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    result_t          res_reg, res_next;

    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic             above_any;
    logic [31:0]      age;
    logic             better;
    logic             match;
    logic             pend_last;
    logic             stall;
    logic             stop_last;
    result_t          stop_res;
    logic [IDX_W+3:0] free_ext, pend_ext, best_ext;

    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        above_any = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (valid_reg[j] && (j > int'(pend_idx_reg)))
            begin
                above_any = 1'b1;
            end
        end
    end

    assign free_any  = ~&valid_reg;
    assign free_ext  = {4'b0, free_idx};
    assign pend_ext  = {4'b0, pend_idx_reg};
    assign best_ext  = {4'b0, best_idx_reg};
    assign age       = req_reg.now_ms - rd_data.start;
    assign better    = (rd_data.prio > best_prio_reg)
                    || ((rd_data.prio == best_prio_reg) && (age > best_age_reg));
    assign match     = valid_reg[pend_idx_reg] && (rd_data.owner == req_reg.voice_handle);
    assign pend_last = (pend_idx_reg == IDX_W'(SLOTS - 1));
    assign stall     = (req_reg.command == CMD_STOP) && pend_vld_reg
                    && valid_reg[pend_idx_reg] && !emit_ready;
    assign stop_last = !above_any || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    always_comb
    begin
        stop_res.action          = ACT_STOP;
        stop_res.slot_index      = pend_ext[3:0];
        stop_res.victim_handle   = rd_data.owner;
        stop_res.victim_sound_id = rd_data.sound;
        stop_res.age_ms          = '0;
        stop_res.last            = stop_last;
    end

    assign emit_data = (state_reg == ST_EMIT) ? res_reg : stop_res;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        best_prio_next  = best_prio_reg;
        best_age_next   = best_age_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_owner_next = best_owner_reg;
        best_sound_next = best_sound_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = free_idx;
        wr_data.prio    = req_reg.voice_priority;
        wr_data.sound   = req_reg.sound_id;
        wr_data.owner   = req_reg.voice_handle;
        wr_data.start   = req_reg.now_ms;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        emit_valid      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = in_req;
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                idx_next        = '0;
                issue_done_next = 1'b0;
                pend_vld_next   = 1'b0;
                best_prio_next  = req_reg.voice_priority;
                best_age_next   = '0;
                found_next      = 1'b0;
                cnt_next        = '0;
                state_next      = ST_SCAN;
                if (req_reg.command == CMD_PLAY && free_any)
                begin
                    wr_en                    = 1'b1;
                    valid_next[free_idx]     = 1'b1;
                    res_next                 = '0;
                    res_next.action          = ACT_GRANTED;
                    res_next.slot_index      = free_ext[3:0];
                    res_next.last            = 1'b1;
                    state_next               = ST_EMIT;
                end
                else if (req_reg.command == CMD_STOP && !(|valid_reg))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    // issue the next read while the previous entry is evaluated
                    if (!issue_done_next && !issue_done_reg)
                    begin
                        rd_en         = 1'b1;
                        pend_vld_next = 1'b1;
                        pend_idx_next = idx_reg;
                        idx_next      = idx_reg + 1'b1;
                        if (idx_reg == IDX_W'(SLOTS - 1))
                        begin
                            issue_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pend_vld_next = 1'b0;
                    end

                    if (pend_vld_reg)
                    begin
                        case (req_reg.command)
                            CMD_PLAY:
                            begin
                                if (better)
                                begin
                                    best_prio_next  = rd_data.prio;
                                    best_age_next   = age;
                                    found_next      = 1'b1;
                                    best_idx_next   = pend_idx_reg;
                                    best_owner_next = rd_data.owner;
                                    best_sound_next = rd_data.sound;
                                end
                                if (pend_last)
                                begin
                                    res_next        = '0;
                                    res_next.last   = 1'b1;
                                    res_next.action = ACT_REJECTED;
                                    if (better)
                                    begin
                                        res_next.action          = ACT_PREEMPT;
                                        res_next.slot_index      = pend_ext[3:0];
                                        res_next.victim_handle   = rd_data.owner;
                                        res_next.victim_sound_id = rd_data.sound;
                                    end
                                    else if (found_reg)
                                    begin
                                        res_next.action          = ACT_PREEMPT;
                                        res_next.slot_index      = best_ext[3:0];
                                        res_next.victim_handle   = best_owner_reg;
                                        res_next.victim_sound_id = best_sound_reg;
                                    end
                                    state_next = ST_EMIT;
                                end
                            end

                            CMD_REMOVE, CMD_QUERY:
                            begin
                                if (match)
                                begin
                                    res_next            = '0;
                                    res_next.last       = 1'b1;
                                    res_next.slot_index = pend_ext[3:0];
                                    if (req_reg.command == CMD_REMOVE)
                                    begin
                                        res_next.action          = ACT_REMOVED;
                                        valid_next[pend_idx_reg] = 1'b0;
                                    end
                                    else
                                    begin
                                        res_next.action = ACT_AGE;
                                        res_next.age_ms = age;
                                    end
                                    state_next = ST_EMIT;
                                end
                                else if (pend_last)
                                begin
                                    res_next        = '0;
                                    res_next.last   = 1'b1;
                                    res_next.action = ACT_NOT_FOUND;
                                    state_next      = ST_EMIT;
                                end
                            end

                            default:
                            begin
                                if (valid_reg[pend_idx_reg])
                                begin
                                    emit_valid = 1'b1;
                                    cnt_next   = cnt_reg + 1'b1;
                                    if (stop_last)
                                    begin
                                        state_next = ST_IDLE;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end

            ST_EMIT:
            begin
                emit_valid = 1'b1;
                if (emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            issue_done_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            issue_done_reg <= issue_done_next;
            pend_vld_reg   <= pend_vld_next;
            found_reg      <= found_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        best_prio_reg  <= best_prio_next;
        best_age_reg   <= best_age_next;
        best_idx_reg   <= best_idx_next;
        best_owner_reg <= best_owner_next;
        best_sound_reg <= best_sound_next;
        res_reg        <= res_next;
    end

endmodule
`default_nettype wire

// ===== rtl/priority_voice_slot_allocator.sv =====
// A play request that finds a free slot is answered without a scan of the slot memory;
// a preemption search, remove, age query or stop-all reads the slot memory one entry a
// cycle, pausing in a stop-all while a result waits on a full output register.
// One transaction at a time; the next is taken once the current one is done.
// Reset clears all valid bits (every slot free); the slot memory itself is not cleared.
`default_nettype none
module priority_voice_slot_allocator
    import pvsa_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // voice_handle[31:0], sound_id[47:32], voice_priority[55:48], now_ms[87:56]
    input  wire logic [87:0] s_axis_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // slot_index[3:0], victim_handle[35:4], victim_sound_id[51:36], age_ms[83:52], zero pad
    output logic [87:0]      m_axis_tdata,
    // action[2:0]
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int IDX_W = $clog2(SLOTS);

    req_t             in_req;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             emit_valid;
    logic             emit_ready;
    result_t          emit_data;
    logic             out_vld_reg, out_vld_next;
    result_t          out_res_reg, out_res_next;

    assign in_req.command        = s_axis_tuser;
    assign in_req.voice_handle   = s_axis_tdata[31:0];
    assign in_req.sound_id       = s_axis_tdata[47:32];
    assign in_req.voice_priority = s_axis_tdata[55:48];
    assign in_req.now_ms         = s_axis_tdata[87:56];

    pvsa_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pvsa_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (in_req),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_data  (emit_data)
    );

    // output register takes a new result whenever it is empty or being drained
    assign emit_ready = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (emit_ready)
        begin
            out_vld_next = emit_valid;
            if (emit_valid)
            begin
                out_res_next = emit_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_res_reg.action;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {4'b0, out_res_reg.age_ms, out_res_reg.victim_sound_id,
                            out_res_reg.victim_handle, out_res_reg.slot_index};

endmodule
`default_nettype wire
